### rtl/core/wgv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-gated Vigenere package
// Shared constants for the word-gated Vigenere encrypt unit.
// ----------------------------------------------------------------------------
package wgv_pkg;

    // Configuration port geometry. The 60-bit key needs a 64-bit data bus, so
    // registers sit at a stride of 8 bytes and bit 3 of the address picks one.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;

    typedef enum logic [0:0] {
        REG_KEY_LETTERS = 1'b0,
        REG_KEY_LENGTH  = 1'b1
    } wgv_reg_idx_t;

    // Width of the key length register.
    localparam int LEN_W = 4;

    // Bits per key letter, and the character codes that the cipher uses.
    localparam int KEY_LETTER_W = 5;
    localparam logic [7:0] CH_A     = 8'd97;
    localparam logic [7:0] CH_E     = 8'd101;
    localparam logic [7:0] CH_I     = 8'd105;
    localparam logic [7:0] CH_O     = 8'd111;
    localparam logic [7:0] CH_U     = 8'd117;
    localparam logic [7:0] CH_Z     = 8'd122;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [5:0] ALPHA    = 6'd26;

endpackage

### rtl/core/wgv_char_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-gated Vigenere character step
// Holds the key position and word mode, and encrypts one byte per step.
// ----------------------------------------------------------------------------
module wgv_char_step #(
    parameter int KEY_MAX = 12
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           step,
    input  logic [7:0]                                     msg_char,
    input  logic                                           line_start,
    input  logic [wgv_pkg::KEY_LETTER_W*KEY_MAX-1:0]       key_letters,
    input  logic [wgv_pkg::LEN_W-1:0]                      key_length,
    output logic [7:0]                                     res_char
);

    localparam int LW    = wgv_pkg::LEN_W;
    localparam int KW    = wgv_pkg::KEY_LETTER_W;
    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [POS_W-1:0] key_pos_reg;
    logic [POS_W-1:0] key_pos_next;
    logic             encrypt_word_reg;
    logic             encrypt_word_next;
    logic             after_space_reg;
    logic             after_space_next;

    logic [LW-1:0]    eff_len;
    logic             is_vowel;
    logic             is_letter;
    logic             do_encrypt;
    logic [POS_W-1:0] pos_use;
    logic [LW-1:0]    pos_inc;
    logic [KW-1:0]    key_arr [KEY_MAX];
    logic [5:0]       sum;
    logic [5:0]       sum_mod;

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            key_arr[i] = key_letters[i*KW +: KW];
        end
    end

    always_comb
    begin
        eff_len = key_length;
        if (key_length == '0)
        begin
            eff_len = LW'(1);
        end
        else if (key_length > LW'(KEY_MAX))
        begin
            eff_len = LW'(KEY_MAX);
        end
    end

    assign is_vowel  = (msg_char == wgv_pkg::CH_A) || (msg_char == wgv_pkg::CH_E)
                    || (msg_char == wgv_pkg::CH_I) || (msg_char == wgv_pkg::CH_O)
                    || (msg_char == wgv_pkg::CH_U);
    assign is_letter = (msg_char >= wgv_pkg::CH_A) && (msg_char <= wgv_pkg::CH_Z);

    always_comb
    begin
        // The first byte of a line or of a word decides the word's mode.
        if (line_start || after_space_reg)
        begin
            encrypt_word_next = !is_vowel;
        end
        else
        begin
            encrypt_word_next = encrypt_word_reg;
        end

        pos_use = line_start ? '0 : key_pos_reg;
        if (LW'(pos_use) >= eff_len)
        begin
            pos_use = '0;
        end

        do_encrypt = encrypt_word_next && is_letter;

        // Key letter plus plain letter is at most 56, so two subtract steps
        // bring it into 0..25.
        sum = 6'(key_arr[pos_use]) + 6'(msg_char - wgv_pkg::CH_A);
        sum_mod = sum;
        if (sum_mod >= wgv_pkg::ALPHA)
        begin
            sum_mod = sum_mod - wgv_pkg::ALPHA;
        end
        if (sum_mod >= wgv_pkg::ALPHA)
        begin
            sum_mod = sum_mod - wgv_pkg::ALPHA;
        end

        pos_inc = LW'(pos_use) + LW'(1);
        if (do_encrypt)
        begin
            key_pos_next = (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
            res_char     = wgv_pkg::CH_A + 8'(sum_mod);
        end
        else
        begin
            key_pos_next = pos_use;
            res_char     = msg_char;
        end

        after_space_next = (msg_char == wgv_pkg::CH_SPACE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg      <= '0;
            encrypt_word_reg <= 1'b1;
            after_space_reg  <= 1'b0;
        end
        else if (step)
        begin
            key_pos_reg      <= key_pos_next;
            encrypt_word_reg <= encrypt_word_next;
            after_space_reg  <= after_space_next;
        end
    end

`ifndef SYNTHESIS
    // The key position always points inside the key store, even after the
    // key length has been shortened.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(key_pos_reg) < LW'(KEY_MAX))
        else $error("key position beyond the key store");

    // An encrypted byte is always a lower-case letter.
    a_enc_is_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (step && do_encrypt) |->
            (res_char >= wgv_pkg::CH_A) && (res_char <= wgv_pkg::CH_Z))
        else $error("encrypted byte outside a to z");

    // A space always leaves the after-space flag set for the next byte.
    a_space_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (msg_char == wgv_pkg::CH_SPACE)) |=> after_space_reg)
        else $error("after-space flag not set by a space");
`endif

endmodule

### rtl/core/word_gated_vigenere_encrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-gated Vigenere encrypt unit
// Encrypts a byte stream word by word with a programmable Vigenere key.
// ----------------------------------------------------------------------------
// Usage:
// Message bytes enter on the input channel (in_valid/in_ready with msg_char
// and line_start) and encrypted bytes leave on the output channel
// (out_valid/out_ready with out_char). Every input transfer produces exactly
// one output transfer, in order.
// A byte is captured in the input register when it is transferred, and its
// result is registered in the output register when that register next loads.
// It takes one byte per cycle while the receiver does not stall; the rate is
// set by the per-byte update of the key position and word mode in the step.
// When the receiver stalls, the output register holds its byte and the
// input register can still take one more byte; further input transfers wait
// until the output drains. in_ready depends on out_ready combinationally.
// At reset both registers empty, the key position is zero, the word mode is
// encrypt, the key is all 'a' and the key length is one.
// The key and key length are written over the APB port at byte addresses 0
// and 8; they should be changed only while no bytes are in flight.
// ----------------------------------------------------------------------------
module word_gated_vigenere_encrypt_unit #(
    parameter int KEY_MAX = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   msg_char,
    input  logic                         line_start,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_char,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wgv_pkg::ADDR_W-1:0]   paddr,
    input  logic [wgv_pkg::DATA_W-1:0]   pwdata,
    output logic [wgv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int KEY_W = wgv_pkg::KEY_LETTER_W * KEY_MAX;
    localparam int LW    = wgv_pkg::LEN_W;

    // Configuration registers.
    logic [KEY_W-1:0]          key_letters_reg;
    logic [LW-1:0]             key_length_reg;
    logic                      cfg_write;
    wgv_pkg::wgv_reg_idx_t     reg_idx;

    // Input stage.
    logic                      s1_valid_reg;
    logic [7:0]                s1_char_reg;
    logic                      s1_line_start_reg;

    // Output stage.
    logic                      out_valid_reg;
    logic [7:0]                out_char_reg;

    logic                      out_load;
    logic                      s1_load;
    logic [7:0]                res_char;

    // ------------------------------------------------------------------
    // APB register port. Bit 3 of the address selects the register, so the
    // key sits at byte address 0 and the key length at byte address 8.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = wgv_pkg::wgv_reg_idx_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_letters_reg <= '0;
            key_length_reg  <= LW'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                wgv_pkg::REG_KEY_LETTERS: key_letters_reg <= pwdata[KEY_W-1:0];
                wgv_pkg::REG_KEY_LENGTH:  key_length_reg  <= pwdata[LW-1:0];
                default:                  key_length_reg  <= key_length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wgv_pkg::REG_KEY_LETTERS: prdata = wgv_pkg::DATA_W'(key_letters_reg);
            wgv_pkg::REG_KEY_LENGTH:  prdata = wgv_pkg::DATA_W'(key_length_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Two-register pipeline. The output register loads whenever it is empty
    // or its byte is being taken; the input register then hands its byte on
    // and can take a new one in the same cycle.
    // ------------------------------------------------------------------
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_char_reg       <= msg_char;
            s1_line_start_reg <= line_start;
        end
    end

    // The character step updates its key position and word mode exactly
    // once per byte, when the byte moves into the output register.
    wgv_char_step #(
        .KEY_MAX    (KEY_MAX)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_valid_reg && out_load),
        .msg_char   (s1_char_reg),
        .line_start (s1_line_start_reg),
        .key_letters(key_letters_reg),
        .key_length (key_length_reg),
        .res_char   (res_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_char_reg <= res_char;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;

`ifndef SYNTHESIS
    // A byte taken into the input register is there on the next cycle.
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg)
        else $error("accepted byte lost from the input register");

    // A stalled input byte stays in place until the output stage frees up.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_char_reg)))
        else $error("input register changed while the output stalled");

    // A result appears only when the input stage held a byte the cycle before.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result produced without an input byte");
`endif

endmodule

### bench/wgv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-gated Vigenere checker
// Tracks register writes, predicts each output byte and compares in order.
// ----------------------------------------------------------------------------
module wgv_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [7:0]                   msg_char,
    input  logic                         line_start,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [7:0]                   out_char,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wgv_pkg::ADDR_W-1:0]   paddr,
    input  logic [wgv_pkg::DATA_W-1:0]   pwdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           in_flight
);
    import wgv_pkg::*;

    localparam int KEY_LIMIT = 12;

    logic [59:0]      key_letters_q;
    logic [LEN_W-1:0] key_len_q;
    logic [3:0]       key_pos;
    logic             encrypt_word;
    logic             after_space;
    logic [7:0]       cipher_chars[$];

    function automatic bit is_vowel(input logic [7:0] c);
        return c == CH_A || c == CH_E || c == CH_I || c == CH_O || c == CH_U;
    endfunction

    // Advances the cipher state by one byte and returns the byte it turns into.
    function automatic logic [7:0] encipher(input logic [7:0] c, input logic ls);
        int          len;
        int          k;
        int          p;
        logic [7:0]  res;
        len = int'(key_len_q);
        if (len == 0)
            len = 1;
        if (len > KEY_LIMIT)
            len = KEY_LIMIT;
        res = c;
        if (ls) begin
            key_pos      = '0;
            encrypt_word = !is_vowel(c);
        end else if (after_space) begin
            encrypt_word = !is_vowel(c);
        end
        if (int'(key_pos) >= len)
            key_pos = '0;
        if (c != CH_SPACE && encrypt_word && c >= CH_A && c <= CH_Z) begin
            k   = int'(key_letters_q[KEY_LETTER_W*key_pos +: KEY_LETTER_W]);
            p   = int'(c - CH_A);
            res = 8'(int'(CH_A) + (k + p) % int'(ALPHA));
            key_pos = key_pos + 4'd1;
            if (int'(key_pos) >= len)
                key_pos = '0;
        end
        after_space = (c == CH_SPACE);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [7:0] want;
        if (!rst_n) begin
            key_letters_q = '0;
            key_len_q     = 4'd1;
            key_pos       = '0;
            encrypt_word  = 1'b1;
            after_space   = 1'b0;
            cipher_chars.delete();
            mismatches    = 0;
            in_flight     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (wgv_reg_idx_t'(paddr[3]))
                    REG_KEY_LETTERS: key_letters_q = pwdata[59:0];
                    REG_KEY_LENGTH:  key_len_q     = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            // The output side goes first: a byte taken in at this edge cannot
            // leave at the same edge.
            if (out_valid && out_ready) begin
                if (cipher_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output transfer 0x%02h with no byte outstanding",
                                 $realtime, out_char);
                end else begin
                    want = cipher_chars.pop_front();
                    if (out_char !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: out_char expected 0x%02h, got 0x%02h",
                                     $realtime, want, out_char);
                    end
                end
            end
            if (in_valid && in_ready)
                cipher_chars.push_back(encipher(msg_char, line_start));
            in_flight = cipher_chars.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-gated Vigenere encrypt unit testbench
// Drives text-like byte streams through the unit under several key settings
// with random stalls on both channels; a checker beside it scores the output.
// ----------------------------------------------------------------------------
module tb_top;
    import wgv_pkg::*;

    // Nothing may stay without a transfer for this many cycles. The slowest
    // honest stretch is the long receiver hold below, well under this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate receiver hold that backs the unit up.
    localparam int RX_LONG_HOLD   = 80;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 60;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          msg_char;
    logic                line_start;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          out_char;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  mismatches;
    int                  in_flight;
    int                  idle_cycles;
    bit                  rx_hold_req;
    bit                  rx_hold_done;
    bit                  word_start;

    word_gated_vigenere_encrypt_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .msg_char   (msg_char),
        .line_start (line_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    wgv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .msg_char   (msg_char),
        .line_start (line_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle cycles before an item on either side. At least a third of the draws are
    // zero, and a busy side never waits, which gives long back-to-back runs.
    function automatic int draw_gap(input bit busy);
        if (busy || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Produces the next byte of a random text stream: mostly lower-case words
    // separated by spaces, with a new line now and then. Word starts lean
    // towards vowels so that pass-through words are common, and a few bytes
    // are arbitrary noise to cover the pass-through repair and every bit.
    task automatic next_text_byte(output logic [7:0] c, output logic ls);
        int r;
        ls = ($urandom_range(0, 29) == 0);
        r  = $urandom_range(0, 99);
        if (r < 4)
        begin
            c = 8'($urandom_range(0, 255));
        end
        else if (r < 20)
        begin
            c = CH_SPACE;
        end
        else if ((word_start || ls) && r < 50)
        begin
            case ($urandom_range(0, 4))
                0:       c = CH_A;
                1:       c = CH_E;
                2:       c = CH_I;
                3:       c = CH_O;
                default: c = CH_U;
            endcase
        end
        else
        begin
            c = 8'($urandom_range(CH_A, CH_Z));
        end
        word_start = (c == CH_SPACE);
    endtask

    // Offers one byte after an optional gap and returns at the edge where the
    // transfer happens. With no gap, valid simply stays high for the next
    // byte, so it never gets two assignments in one time step.
    task automatic push_byte(input logic [7:0] c, input logic ls, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        msg_char   <= c;
        line_start <= ls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering bytes and waits until every predicted byte has come
    // out. The count is read at the falling edge, clear of the checker's
    // update at the rising one.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (in_flight != 0);
        repeat (2) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle. pready is always high,
    // so the register takes the data at the end of the access cycle. The
    // trailing idle cycle keeps back-to-back writes from lowering and raising
    // psel in the same step.
    task automatic apb_write(input wgv_reg_idx_t idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_key(input logic [59:0] letters, input logic [3:0] len);
        apb_write(REG_KEY_LETTERS, DATA_W'(letters));
        apb_write(REG_KEY_LENGTH, DATA_W'(len));
    endtask

    // Receiver. It draws a wait before each byte and, once asked, holds off
    // for a long stretch counted here so that the unit fills up and pushes
    // back on its input. Every forty bytes it may switch to a stall-free run.
    initial
    begin : sink
        int gap;
        int served;
        bit rx_busy;
        out_ready    <= 1'b0;
        rx_hold_done  = 1'b0;
        served        = 0;
        rx_busy       = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (served % 40 == 0)
                rx_busy = ($urandom_range(0, 2) == 0);
            if (rx_hold_req && !rx_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge clk);
                rx_hold_done = 1'b1;
            end
            gap = draw_gap(rx_busy);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            served++;
        end
    end

    // Any transfer or register access clears the idle count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("** word_gated_vigenere_encrypt_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        // Opening stream, each entry {line_start, byte}. It covers bytes
        // before any line start, a vowel word inside a line, consecutive
        // spaces, noise bytes at both ends of the range and just outside the
        // letters, line starts on a vowel, a space and a noise byte, a key
        // wrap, and an upper-case byte that decides a word's mode.
        logic [8:0]  opening [0:25] = '{
            {1'b0, CH_Z},     {1'b0, CH_A},     {1'b0, CH_SPACE}, {1'b0, CH_E},
            {1'b0, "x"},      {1'b0, CH_SPACE}, {1'b0, CH_SPACE}, {1'b0, "q"},
            {1'b0, 8'h00},    {1'b0, 8'hff},    {1'b0, 8'h60},    {1'b0, 8'h7b},
            {1'b1, CH_O},     {1'b0, "m"},      {1'b1, CH_SPACE}, {1'b0, CH_U},
            {1'b1, "b"},      {1'b0, "y"},      {1'b0, CH_Z},     {1'b0, CH_A},
            {1'b0, "c"},      {1'b1, 8'h80},    {1'b0, CH_I},     {1'b0, CH_SPACE},
            {1'b0, "A"},      {1'b0, "k"}
        };
        logic [7:0]  c;
        logic        ls;
        logic [59:0] letters;
        logic [3:0]  len;
        bit          tx_busy;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        msg_char   <= '0;
        line_start <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        rx_hold_req = 1'b0;
        word_start  = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A three-letter key of z, then the out-of-alphabet codes 31 and 26.
        program_key(60'habc_def0_1234_6bf9, 4'd3);
        foreach (opening[i])
            push_byte(opening[i][7:0], opening[i][8], draw_gap(1'b0));

        // Random text under a series of key settings. The state carries over
        // from one phase to the next, so a shorter key length meets a key
        // position left beyond it. Lengths of zero and above the maximum are
        // written too, as is an all-ones key.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_drain();
            letters = 60'({$urandom, $urandom});
            case (phase)
                0:
                begin
                    letters = '1;
                    len     = 4'd12;
                end
                1:
                begin
                    letters = '0;
                    len     = 4'd0;
                end
                2:       len = 4'd15;
                3:       len = 4'd1;
                4:       len = 4'd5;
                5:       len = 4'd12;
                6:       len = 4'd13;
                default: len = 4'($urandom_range(1, 12));
            endcase
            program_key(letters, len);
            // Phase four backs the unit up: the receiver holds off while the
            // sender keeps offering bytes with no gaps.
            tx_busy = (phase == 1 || phase == 4 || phase == 5);
            if (phase == 4)
                rx_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                next_text_byte(c, ls);
                push_byte(c, ls, draw_gap(tx_busy));
            end
        end

        wait_for_drain();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("** word_gated_vigenere_encrypt_unit: PASSED **");
        else
            $display("** word_gated_vigenere_encrypt_unit: FAILED **");
        $finish;
    end

endmodule

### word_gated_vigenere_encrypt_unit.f
rtl/core/wgv_pkg.sv
rtl/core/wgv_char_step.sv
rtl/core/word_gated_vigenere_encrypt_unit.sv
bench/wgv_checker.sv
bench/tb_top.sv
